// ===== rtl/tsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tsm_pkg - shared types and constants for the touch sample settle and map block
// Item layouts, register indexes, status codes and reset values.
// ----------------------------------------------------------------------------
package tsm_pkg;

	localparam int DEF_RING_SIZE   = 4;
	localparam int DEF_MAX_RETRIES = 16;
	localparam int MAX_DIFF        = 4;
	localparam int FULL_SCALE      = 4096;

	localparam int READING_W   = 12;
	localparam int PIX_W       = 12;
	localparam int CFG_W       = 13;
	localparam int ORIENT_W    = 3;
	localparam int CFG_INDEX_W = 3;
	localparam int QUEUE_DEPTH = 2;

	// mapping divider: |raw - low| (13 bits) times size (13 bits)
	localparam int MAP_DIV_W = 2 * CFG_W;

	// result status codes
	localparam logic [1:0] ST_X_UNSETTLED = 2'd0;
	localparam logic [1:0] ST_Y_UNSETTLED = 2'd1;
	localparam logic [1:0] ST_PEN_UP      = 2'd2;
	localparam logic [1:0] ST_VALID       = 2'd3;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_ORIENTATION    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_WIDTH  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_HEIGHT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CAL_LEFT       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_CAL_RIGHT      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_CAL_TOP        = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_CAL_BOTTOM     = 3'd6;

	// register reset values
	localparam logic [ORIENT_W-1:0] RST_ORIENTATION    = 3'd0;
	localparam logic [CFG_W-1:0]    RST_DISPLAY_WIDTH  = 13'd800;
	localparam logic [CFG_W-1:0]    RST_DISPLAY_HEIGHT = 13'd480;
	localparam logic [CFG_W-1:0]    RST_CAL_LEFT       = 13'd0;
	localparam logic [CFG_W-1:0]    RST_CAL_RIGHT      = 13'd4095;
	localparam logic [CFG_W-1:0]    RST_CAL_TOP        = 13'd0;
	localparam logic [CFG_W-1:0]    RST_CAL_BOTTOM     = 13'd4095;

	typedef struct packed {
		logic [READING_W-1:0] reading;
		logic                 channel;
		logic                 group_start;
		logic                 pen_down;
	} sample_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [PIX_W-1:0] x_pixel;
		logic [PIX_W-1:0] y_pixel;
	} result_t;

	typedef struct packed {
		logic [ORIENT_W-1:0] orientation;
		logic [CFG_W-1:0]    display_width;
		logic [CFG_W-1:0]    display_height;
		logic [CFG_W-1:0]    cal_left;
		logic [CFG_W-1:0]    cal_right;
		logic [CFG_W-1:0]    cal_top;
		logic [CFG_W-1:0]    cal_bottom;
	} cfg_t;

	// work handed from the settle filter to the mapper
	typedef struct packed {
		logic                 is_map;
		logic [1:0]           status;
		logic [READING_W-1:0] tx;
		logic [READING_W-1:0] ty;
	} job_t;

endpackage

// ===== rtl/tsm_front.sv =====
// ----------------------------------------------------------------------------
// tsm_front - settle filter
// Keeps the ring of readings per channel group, averages it with a reciprocal
// multiply by the ring size, checks the spread and hands jobs to the queue.
// ----------------------------------------------------------------------------
module tsm_front #(
	parameter int RING_SIZE   = tsm_pkg::DEF_RING_SIZE,
	parameter int MAX_RETRIES = tsm_pkg::DEF_MAX_RETRIES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_ready,
	input  tsm_pkg::sample_t sample,
	output logic             push,
	output tsm_pkg::job_t    job,
	input  logic             full
);

	localparam int RW      = tsm_pkg::READING_W;
	localparam int IDX_W   = $clog2(RING_SIZE);
	localparam int FILL_W  = $clog2(RING_SIZE + 1);
	localparam int SUM_W   = RW + $clog2(RING_SIZE);
	localparam int RETRY_W = $clog2(MAX_RETRIES + 1);
	localparam int REC_S   = SUM_W + $clog2(RING_SIZE);
	localparam int PROD_W  = 2 * SUM_W + 1;
	// reciprocal of the ring size, exact for every sum that fits SUM_W bits
	localparam longint REC_ML = ((longint'(1) << REC_S) + longint'(RING_SIZE) - 1)
		/ longint'(RING_SIZE);
	localparam logic [SUM_W:0] REC_M = (SUM_W + 1)'(REC_ML);

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_CHECK, F_EMIT} fstate_t;

	fstate_t             state_q;
	logic [RW-1:0]       ring_q [RING_SIZE];
	logic [SUM_W-1:0]    sum_q;
	logic [FILL_W-1:0]   fill_q;
	logic [IDX_W-1:0]    slot_q;
	logic [RETRY_W-1:0]  retry_q;
	logic [RW-1:0]       settled_x_q;
	logic                grp_chan_q;
	logic                grp_active_q;
	logic                x_ready_q;
	logic                pen_q;
	logic [SUM_W-1:0]    div_q;
	tsm_pkg::job_t       job_q;

	logic                accept;
	logic                act_eff;
	logic                chan_eff;
	logic                take;
	logic [FILL_W-1:0]   fill_eff;
	logic [SUM_W-1:0]    sum_eff;
	logic [RETRY_W-1:0]  retry_eff;
	logic                filling;
	logic [FILL_W-1:0]   fill_inc;
	logic [RETRY_W-1:0]  retry_inc;
	logic [IDX_W-1:0]    wr_idx;
	logic [IDX_W-1:0]    slot_next;
	logic [SUM_W-1:0]    sum_new;
	logic                failed;
	logic                need_check;
	logic [PROD_W-1:0]   quot_prod;
	logic [RW-1:0]       avg;
	logic                unsettled;

	assign sample_ready = (state_q == F_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign push         = (state_q == F_EMIT) && !full;
	assign job          = job_q;

	// a group start resets the group before the reading is looked at
	always_comb begin
		act_eff   = sample.group_start ? (!sample.channel || x_ready_q) : grp_active_q;
		chan_eff  = sample.group_start ? sample.channel : grp_chan_q;
		fill_eff  = sample.group_start ? '0 : fill_q;
		sum_eff   = sample.group_start ? '0 : sum_q;
		retry_eff = sample.group_start ? '0 : retry_q;
		take      = act_eff && (sample.channel == chan_eff);
		filling   = fill_eff < FILL_W'(RING_SIZE);
		fill_inc  = fill_eff + FILL_W'(1);
		retry_inc = retry_eff + RETRY_W'(1);
		wr_idx    = filling ? fill_eff[IDX_W-1:0] : slot_q;
		slot_next = (slot_q == IDX_W'(RING_SIZE - 1)) ? '0 : slot_q + IDX_W'(1);
		sum_new   = sum_eff + SUM_W'(sample.reading)
			- (filling ? SUM_W'(0) : SUM_W'(ring_q[slot_q]));
		failed     = !filling && (retry_inc >= RETRY_W'(MAX_RETRIES));
		need_check = filling ? (fill_inc == FILL_W'(RING_SIZE)) : !failed;
	end

	// average of the ring: sum times the reciprocal, top bits kept
	assign quot_prod = PROD_W'(div_q) * PROD_W'(REC_M);
	assign avg       = div_q[RW-1:0];

	always_comb begin : p_spread
		logic [RW-1:0] dif;
		unsettled = 1'b0;
		dif       = '0;
		for (int i = 0; i < RING_SIZE; i++) begin
			dif = (avg > ring_q[i]) ? avg - ring_q[i] : ring_q[i] - avg;
			if (dif >= RW'(tsm_pkg::MAX_DIFF)) begin
				unsettled = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && take) begin
			ring_q[wr_idx] <= sample.reading;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			sum_q        <= '0;
			fill_q       <= '0;
			slot_q       <= '0;
			retry_q      <= '0;
			settled_x_q  <= '0;
			grp_chan_q   <= 1'b0;
			grp_active_q <= 1'b0;
			x_ready_q    <= 1'b0;
			pen_q        <= 1'b0;
			div_q        <= '0;
			job_q        <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (sample.group_start) begin
							grp_chan_q   <= sample.channel;
							grp_active_q <= act_eff;
							if (!sample.channel) begin
								x_ready_q <= 1'b0;
							end
						end
						if (take) begin
							sum_q   <= sum_new;
							fill_q  <= filling ? fill_inc : fill_eff;
							retry_q <= filling ? retry_eff : retry_inc;
							slot_q  <= (filling && sample.group_start) ? '0 :
								(filling ? slot_q : slot_next);
							if (failed) begin
								grp_active_q <= 1'b0;
								if (!chan_eff) begin
									x_ready_q <= 1'b0;
								end
								job_q.is_map <= 1'b0;
								job_q.status <= chan_eff ? tsm_pkg::ST_Y_UNSETTLED :
									tsm_pkg::ST_X_UNSETTLED;
								job_q.tx     <= '0;
								job_q.ty     <= '0;
								state_q      <= F_EMIT;
							end else if (need_check) begin
								pen_q   <= sample.pen_down;
								div_q   <= sum_new;
								state_q <= F_DIV;
							end
						end else if (sample.group_start) begin
							sum_q   <= '0;
							fill_q  <= '0;
							slot_q  <= '0;
							retry_q <= '0;
						end
					end
				end
				F_DIV: begin
					div_q   <= SUM_W'(quot_prod[REC_S +: RW]);
					state_q <= F_CHECK;
				end
				F_CHECK: begin
					if (unsettled) begin
						state_q <= F_IDLE;
					end else begin
						grp_active_q <= 1'b0;
						if (!grp_chan_q) begin
							settled_x_q <= avg;
							x_ready_q   <= 1'b1;
							state_q     <= F_IDLE;
						end else begin
							x_ready_q    <= 1'b0;
							job_q.is_map <= pen_q;
							job_q.status <= pen_q ? tsm_pkg::ST_VALID : tsm_pkg::ST_PEN_UP;
							job_q.tx     <= settled_x_q;
							job_q.ty     <= avg;
							state_q      <= F_EMIT;
						end
					end
				end
				F_EMIT: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(RING_SIZE))
		else $error("ring fill count beyond ring size");

	a_retry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		retry_q <= RETRY_W'(MAX_RETRIES))
		else $error("retry count beyond limit");

	a_x_group_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!(x_ready_q && grp_active_q && !grp_chan_q))
		else $error("settled x flagged while an x group is still open");

endmodule

// ===== rtl/tsm_queue.sv =====
// ----------------------------------------------------------------------------
// tsm_queue - job queue
// Short first-in first-out store between the settle filter and the mapper.
// ----------------------------------------------------------------------------
module tsm_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tsm_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output tsm_pkg::job_t head,
	output logic          empty
);

	localparam int DEPTH = tsm_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	tsm_pkg::job_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign head    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("job pushed into a full queue");

endmodule

// ===== rtl/tsm_back.sv =====
// ----------------------------------------------------------------------------
// tsm_back - coordinate mapper
// Applies orientation, scales each axis through one shared multiplier and
// serial divider, clamps to the display and holds the result item.
// ----------------------------------------------------------------------------
module tsm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tsm_pkg::cfg_t    cfg,
	input  logic             q_empty,
	input  tsm_pkg::job_t    q_head,
	output logic             q_pop,
	output logic             result_valid,
	input  logic             result_ready,
	output tsm_pkg::result_t result
);

	localparam int CW    = tsm_pkg::CFG_W;
	localparam int RW    = tsm_pkg::READING_W;
	localparam int PW    = tsm_pkg::PIX_W;
	localparam int DW    = tsm_pkg::MAP_DIV_W;
	localparam int CNT_W = $clog2(DW);

	typedef enum logic [2:0] {B_IDLE, B_MUL, B_DIV, B_CLAMP, B_OUT} bstate_t;

	bstate_t          state_q;
	logic             axis_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CW-1:0]    vx_q;
	logic [CW-1:0]    vy_q;
	logic [DW-1:0]    dq_q;
	logic [CW-1:0]    rem_q;
	logic [CW-1:0]    divisor_q;
	logic             zero_q;
	logic [CW-1:0]    bound_q;
	logic [PW-1:0]    pix_x_q;
	logic [PW-1:0]    pix_y_q;
	logic [1:0]       st_q;
	logic             result_valid_q;
	tsm_pkg::result_t result_q;

	logic [RW-1:0]    pick_a;
	logic [RW-1:0]    pick_b;
	logic [CW-1:0]    ori_x;
	logic [CW-1:0]    ori_y;
	logic [CW-1:0]    sel_val;
	logic [CW-1:0]    sel_lo;
	logic [CW-1:0]    sel_hi;
	logic [CW-1:0]    sel_size;
	logic [CW:0]      diff;
	logic [CW:0]      diff_neg;
	logic [CW:0]      span;
	logic [CW:0]      span_neg;
	logic [CW-1:0]    diff_mag;
	logic [CW-1:0]    span_mag;
	logic [DW-1:0]    prod;
	logic [CW:0]      rem_sh;
	logic [CW:0]      rem_sub;
	logic             rem_ge;
	logic [PW-1:0]    clamp_pix;
	logic             out_free;

	assign q_pop        = (state_q == B_IDLE) && !q_empty;
	assign out_free     = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// orientation: optional axis swap, then reversal about full scale
	always_comb begin
		pick_a = cfg.orientation[0] ? q_head.ty : q_head.tx;
		pick_b = cfg.orientation[0] ? q_head.tx : q_head.ty;
		ori_x  = cfg.orientation[1] ? CW'(tsm_pkg::FULL_SCALE) - CW'(pick_a) : CW'(pick_a);
		ori_y  = cfg.orientation[2] ? CW'(tsm_pkg::FULL_SCALE) - CW'(pick_b) : CW'(pick_b);
	end

	always_comb begin
		sel_val  = axis_q ? vy_q : vx_q;
		sel_lo   = axis_q ? cfg.cal_top : cfg.cal_left;
		sel_hi   = axis_q ? cfg.cal_bottom : cfg.cal_right;
		sel_size = axis_q ? cfg.display_height : cfg.display_width;
		diff     = {1'b0, sel_val} - {1'b0, sel_lo};
		span     = {1'b0, sel_hi} - {1'b0, sel_lo};
		diff_neg = '0 - diff;
		span_neg = '0 - span;
		diff_mag = diff[CW] ? diff_neg[CW-1:0] : diff[CW-1:0];
		span_mag = span[CW] ? span_neg[CW-1:0] : span[CW-1:0];
		prod     = DW'(diff_mag) * DW'(sel_size);
	end

	assign rem_sh  = {rem_q, dq_q[DW-1]};
	assign rem_sub = rem_sh - {1'b0, divisor_q};
	assign rem_ge  = rem_sh >= {1'b0, divisor_q};

	// negative quotient, zero span or zero size all land on pixel zero
	assign clamp_pix = zero_q ? '0 :
		(dq_q >= DW'(bound_q)) ? PW'(bound_q - CW'(1)) : dq_q[PW-1:0];

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				vx_q <= ori_x;
				vy_q <= ori_y;
			end
			B_MUL: begin
				dq_q      <= prod;
				rem_q     <= '0;
				divisor_q <= span_mag;
				zero_q    <= (span == '0) || (sel_size == '0) || (diff[CW] ^ span[CW]);
				bound_q   <= (sel_size > CW'(tsm_pkg::FULL_SCALE)) ?
					CW'(tsm_pkg::FULL_SCALE) : sel_size;
			end
			B_DIV: begin
				rem_q <= rem_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
				dq_q  <= {dq_q[DW-2:0], rem_ge};
			end
			B_CLAMP: begin
				if (axis_q) begin
					pix_y_q <= clamp_pix;
				end else begin
					pix_x_q <= clamp_pix;
				end
			end
			B_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= B_IDLE;
			axis_q         <= 1'b0;
			cnt_q          <= '0;
			st_q           <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						st_q   <= q_head.status;
						axis_q <= 1'b0;
						state_q <= q_head.is_map ? B_MUL : B_OUT;
					end
				end
				B_MUL: begin
					cnt_q   <= '0;
					state_q <= B_DIV;
				end
				B_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DW - 1)) begin
						state_q <= B_CLAMP;
					end
				end
				B_CLAMP: begin
					axis_q  <= 1'b1;
					state_q <= axis_q ? B_OUT : B_MUL;
				end
				B_OUT: begin
					if (out_free) begin
						result_valid_q  <= 1'b1;
						result_q.status <= st_q;
						result_q.x_pixel <= (st_q == tsm_pkg::ST_VALID) ? pix_x_q : '0;
						result_q.y_pixel <= (st_q == tsm_pkg::ST_VALID) ? pix_y_q : '0;
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/touch_sample_settle_and_map.sv =====
// ----------------------------------------------------------------------------
// touch_sample_settle_and_map - resistive touch settle filter and pixel mapper
// A reading that is ignored or only fills the ring does not hold the input. A
// reading that triggers a spread check holds the input through the reciprocal
// multiply that averages the ring and the spread check, then, if it yields a
// job, until the job is handed over, which waits while the job queue is full.
// A status item goes from the queue head straight to the mapper's output
// state; a coordinate pair is scaled one axis after the other in the shared
// multiplier and 26-step divider, which works while the filter keeps taking
// readings through a two-entry job queue. Registers may be written at any
// time the block is idle; the register port never stalls.
// ----------------------------------------------------------------------------
module touch_sample_settle_and_map #(
	parameter int RING_SIZE   = tsm_pkg::DEF_RING_SIZE,
	parameter int MAX_RETRIES = tsm_pkg::DEF_MAX_RETRIES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  tsm_pkg::sample_t                  sample,
	output logic                              result_valid,
	input  logic                              result_ready,
	output tsm_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tsm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tsm_pkg::CFG_W-1:0]         cfg_data
);

	tsm_pkg::cfg_t cfg_q;
	tsm_pkg::job_t front_job;
	tsm_pkg::job_t q_head;
	logic          front_push;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.orientation    <= tsm_pkg::RST_ORIENTATION;
			cfg_q.display_width  <= tsm_pkg::RST_DISPLAY_WIDTH;
			cfg_q.display_height <= tsm_pkg::RST_DISPLAY_HEIGHT;
			cfg_q.cal_left       <= tsm_pkg::RST_CAL_LEFT;
			cfg_q.cal_right      <= tsm_pkg::RST_CAL_RIGHT;
			cfg_q.cal_top        <= tsm_pkg::RST_CAL_TOP;
			cfg_q.cal_bottom     <= tsm_pkg::RST_CAL_BOTTOM;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tsm_pkg::REG_ORIENTATION:
					cfg_q.orientation <= cfg_data[tsm_pkg::ORIENT_W-1:0];
				tsm_pkg::REG_DISPLAY_WIDTH:  cfg_q.display_width  <= cfg_data;
				tsm_pkg::REG_DISPLAY_HEIGHT: cfg_q.display_height <= cfg_data;
				tsm_pkg::REG_CAL_LEFT:       cfg_q.cal_left       <= cfg_data;
				tsm_pkg::REG_CAL_RIGHT:      cfg_q.cal_right      <= cfg_data;
				tsm_pkg::REG_CAL_TOP:        cfg_q.cal_top        <= cfg_data;
				tsm_pkg::REG_CAL_BOTTOM:     cfg_q.cal_bottom     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tsm_front #(
		.RING_SIZE   (RING_SIZE),
		.MAX_RETRIES (MAX_RETRIES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.push         (front_push),
		.job          (front_job),
		.full         (q_full)
	);

	tsm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_push),
		.push_job (front_job),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	tsm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== dv/touch_sample_settle_and_map_checker.sv =====
// ----------------------------------------------------------------------------
// touch_sample_settle_and_map_checker - reporting checker for the settle and map block
// Watches the sample, register and result channels, keeps its own copy of
// the settle filter state and the registers, works out the report that each
// accepted reading causes and compares every result item field by field with
// the oldest report still due.
// ----------------------------------------------------------------------------
module touch_sample_settle_and_map_checker
	import tsm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	input  logic                   sample_ready,
	input  sample_t                sample,
	input  logic                   result_valid,
	input  logic                   result_ready,
	input  result_t                result,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	output int                     fail_count,
	output int                     pending
);

	localparam int RING    = DEF_RING_SIZE;
	localparam int RETRIES = DEF_MAX_RETRIES;

	// register copy
	logic [ORIENT_W-1:0] orient;
	logic [CFG_W-1:0]    disp_w, disp_h;
	logic [CFG_W-1:0]    cal_l, cal_r, cal_t, cal_b;

	// settle filter copy
	logic [READING_W-1:0] ring [RING];
	logic [13:0]          ring_sum;
	logic [2:0]           fill;
	logic [1:0]           oldest;
	logic [4:0]           retries;
	logic [READING_W-1:0] settled_x;
	logic                 grp_chan, grp_active, x_ready;

	result_t due_reports[$];

	function automatic logic [PIX_W-1:0] pixel_of(logic [CFG_W-1:0] raw, logic [CFG_W-1:0] lo,
			logic [CFG_W-1:0] hi, logic [CFG_W-1:0] size);
		longint span, c, bound;
		span = longint'(hi) - longint'(lo);
		bound = (size > FULL_SCALE) ? longint'(FULL_SCALE) : longint'(size);
		c = 0;
		if (bound == 0) return '0;
		// signed division truncates towards zero
		if (span != 0) c = ((longint'(raw) - longint'(lo)) * longint'(size)) / span;
		if (c < 0) c = 0;
		else if (c >= bound) c = bound - 1;
		return c[PIX_W-1:0];
	endfunction

	task automatic settle_and_map(input sample_t s, output bit emits, output result_t r);
		logic [READING_W-1:0] avg, spread;
		logic [CFG_W-1:0]     vx, vy;
		bit                   failed, calm;
		int                   i;
		emits = 1'b0;
		r = '0;
		failed = 1'b0;
		if (s.group_start) begin
			ring_sum = '0;
			fill = '0;
			oldest = '0;
			retries = '0;
			grp_chan = s.channel;
			if (!s.channel) begin
				x_ready = 1'b0;
				grp_active = 1'b1;
			end else begin
				grp_active = x_ready;
			end
		end
		if (!grp_active || s.channel != grp_chan) return;

		if (fill < RING) begin
			ring[fill[1:0]] = s.reading;
			ring_sum = ring_sum + s.reading;
			fill = fill + 1'b1;
			if (fill < RING) return;
		end else begin
			ring_sum = ring_sum - ring[oldest] + s.reading;
			ring[oldest] = s.reading;
			oldest = oldest + 1'b1;  // ring of four wraps on its own
			retries = retries + 1'b1;
			if (retries >= RETRIES) failed = 1'b1;
		end

		avg = READING_W'(ring_sum / RING);
		calm = 1'b1;
		for (i = 0; i < RING; i++) begin
			spread = (avg > ring[i]) ? avg - ring[i] : ring[i] - avg;
			if (spread >= MAX_DIFF) calm = 1'b0;
		end
		if (!failed && !calm) return;

		grp_active = 1'b0;
		if (failed) begin
			if (!grp_chan) x_ready = 1'b0;
			emits = 1'b1;
			r.status = grp_chan ? ST_Y_UNSETTLED : ST_X_UNSETTLED;
			return;
		end
		if (!grp_chan) begin
			settled_x = avg;
			x_ready = 1'b1;
			return;
		end
		x_ready = 1'b0;
		emits = 1'b1;
		if (!s.pen_down) begin
			r.status = ST_PEN_UP;
			return;
		end
		vx = orient[0] ? avg : settled_x;
		vy = orient[0] ? settled_x : avg;
		if (orient[1]) vx = CFG_W'(FULL_SCALE) - vx;
		if (orient[2]) vy = CFG_W'(FULL_SCALE) - vy;
		r.status = ST_VALID;
		r.x_pixel = pixel_of(vx, cal_l, cal_r, disp_w);
		r.y_pixel = pixel_of(vy, cal_t, cal_b, disp_h);
	endtask

	always @(posedge clk or negedge arst_n) begin
		bit      emits;
		result_t fresh, want;
		if (!arst_n) begin
			orient = RST_ORIENTATION;
			disp_w = RST_DISPLAY_WIDTH;
			disp_h = RST_DISPLAY_HEIGHT;
			cal_l = RST_CAL_LEFT;
			cal_r = RST_CAL_RIGHT;
			cal_t = RST_CAL_TOP;
			cal_b = RST_CAL_BOTTOM;
			ring_sum = '0;
			fill = '0;
			oldest = '0;
			retries = '0;
			settled_x = '0;
			grp_chan = 1'b0;
			grp_active = 1'b0;
			x_ready = 1'b0;
			due_reports.delete();
			fail_count = 0;
		end else begin
			// results first: an item never leaves on the edge its reading arrives
			if (result_valid && result_ready) begin
				if (due_reports.size() == 0) begin
					$error("result item with none due: status %0d x_pixel %0d y_pixel %0d",
						result.status, result.x_pixel, result.y_pixel);
					fail_count++;
				end else begin
					want = due_reports.pop_front();
					if (result.status !== want.status) begin
						$error("status mismatch: expected %0d, got %0d", want.status, result.status);
						fail_count++;
					end
					if (result.x_pixel !== want.x_pixel) begin
						$error("x_pixel mismatch: expected %0d, got %0d",
							want.x_pixel, result.x_pixel);
						fail_count++;
					end
					if (result.y_pixel !== want.y_pixel) begin
						$error("y_pixel mismatch: expected %0d, got %0d",
							want.y_pixel, result.y_pixel);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ORIENTATION:    orient = cfg_data[ORIENT_W-1:0];
					REG_DISPLAY_WIDTH:  disp_w = cfg_data;
					REG_DISPLAY_HEIGHT: disp_h = cfg_data;
					REG_CAL_LEFT:       cal_l = cfg_data;
					REG_CAL_RIGHT:      cal_r = cfg_data;
					REG_CAL_TOP:        cal_t = cfg_data;
					REG_CAL_BOTTOM:     cal_b = cfg_data;
					default: ;
				endcase
			end
			if (sample_valid && sample_ready) begin
				settle_and_map(sample, emits, fresh);
				if (emits) due_reports.push_back(fresh);
			end
		end
		pending = due_reports.size();
	end

endmodule

// ===== dv/touch_sample_settle_and_map_tb.sv =====
// ----------------------------------------------------------------------------
// touch_sample_settle_and_map_tb - regression bench for the settle and map block
// Drives directed readings and then random touch sequences (clean x and y
// groups, noisy groups that run out of retries, lifted pens, stray and
// orphan readings) through several register settings, with random gaps on
// the sample side and random stalls on the result side. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module touch_sample_settle_and_map_tb;
	import tsm_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 200;
	localparam int PHASE_ITEMS  = 170;
	localparam int PHASES       = 7;
	localparam int RING         = DEF_RING_SIZE;
	localparam int FAIL_RUN     = 20;

	// index beyond the register list, written once to show it is ignored
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

	logic                   clk;
	logic                   arst_n;
	logic                   sample_valid, sample_ready;
	sample_t                sample;
	logic                   result_valid, result_ready;
	result_t                result;
	logic                   cfg_valid, cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	int fail_count, pending;
	int cycle_count;
	int counted;
	bit steady;

	touch_sample_settle_and_map dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	touch_sample_settle_and_map_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// result side: stretches of eager draining and stretches of random stalls
	initial begin
		int hold, mode_left, r;
		bit eager;
		result_ready = 1'b0;
		hold = 0;
		mode_left = 0;
		eager = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				eager = ($urandom_range(0, 3) == 0);
				mode_left = $urandom_range(50, 400);
			end
			mode_left--;
			if (hold > 0) begin
				hold--;
				result_ready <= 1'b0;
			end else if (eager) begin
				result_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					result_ready <= 1'b1;
				end else begin
					hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
					result_ready <= 1'b0;
				end
			end
		end
	end

	function automatic sample_t pack_sample(logic [READING_W-1:0] rd, logic ch, logic st, logic pen);
		sample_t s;
		s.reading = rd;
		s.channel = ch;
		s.group_start = st;
		s.pen_down = pen;
		return s;
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic put(input sample_t s);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			sample_valid <= 1'b0;
		end
		@(negedge clk);
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (!sample_ready);
	endtask

	// one channel group: noisy readings first, then either a tight cluster
	// that settles or a long noisy run that exhausts the retries
	task automatic put_group(input logic ch, input int wild, input logic pen, input bit settles);
		logic [READING_W-1:0] base, rd;
		int n, k, r;
		r = $urandom_range(0, 9);
		base = (r == 0) ? 12'd0 : (r == 1) ? 12'd4092 : 12'($urandom_range(0, 4092));
		n = settles ? wild + RING : FAIL_RUN;
		for (k = 0; k < n; k++) begin
			if (k < wild || !settles)
				rd = (k % 2) ? 12'($urandom_range(2048, 4095)) : 12'($urandom_range(0, 2047));
			else
				rd = base + 12'($urandom_range(0, 3));
			put(pack_sample(rd, ch, k == 0, ch ? pen : 1'($urandom_range(0, 1))));
			counted++;
			// stray reading on the other channel
			if ($urandom_range(0, 19) == 0)
				put(pack_sample(12'($urandom), ~ch, 1'b0, 1'($urandom_range(0, 1))));
		end
	endtask

	task automatic run_random(input int n);
		int kind, k;
		while (counted < n) begin
			steady = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				put_group(1'b0, $urandom_range(0, 3), 1'b0, 1'b1);
				put_group(1'b1, $urandom_range(0, 3), $urandom_range(0, 9) != 0, 1'b1);
			end else if (kind < 65) begin
				put_group(1'b0, 0, 1'b0, 1'b0);
			end else if (kind < 75) begin
				put_group(1'b0, $urandom_range(0, 3), 1'b0, 1'b1);
				put_group(1'b1, 0, 1'b1, 1'b0);
			end else if (kind < 85) begin
				put_group(1'b0, $urandom_range(0, 3), 1'b0, 1'b1);
				put_group(1'b1, $urandom_range(0, 3), 1'b0, 1'b1);
			end else if (kind < 93) begin
				repeat ($urandom_range(1, 4))
					put(pack_sample(12'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)));
			end else begin
				// y group with no x group put in front of it
				for (k = 0; k < 3; k++)
					put(pack_sample(12'($urandom), 1'b1, k == 0, 1'b1));
			end
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_settings(input logic [CFG_W-1:0] o, input logic [CFG_W-1:0] w,
			input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] l, input logic [CFG_W-1:0] r,
			input logic [CFG_W-1:0] t, input logic [CFG_W-1:0] b);
		write_reg(REG_ORIENTATION, o);
		write_reg(REG_DISPLAY_WIDTH, w);
		write_reg(REG_DISPLAY_HEIGHT, h);
		write_reg(REG_CAL_LEFT, l);
		write_reg(REG_CAL_RIGHT, r);
		write_reg(REG_CAL_TOP, t);
		write_reg(REG_CAL_BOTTOM, b);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int p;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 1'b0;
		counted = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// directed: no group yet, y before x, channel mismatch, full-scale
		// coordinates, reading after the group finished, lifted pen
		put(pack_sample(12'd0, 1'b0, 1'b0, 1'b0));
		put(pack_sample(12'hFFF, 1'b1, 1'b1, 1'b1));
		put(pack_sample(12'd0, 1'b0, 1'b1, 1'b1));
		put(pack_sample(12'd0, 1'b0, 1'b0, 1'b0));
		put(pack_sample(12'hFFF, 1'b1, 1'b0, 1'b1));
		put(pack_sample(12'd0, 1'b0, 1'b0, 1'b1));
		put(pack_sample(12'd0, 1'b0, 1'b0, 1'b0));
		put(pack_sample(12'hFFF, 1'b1, 1'b1, 1'b1));
		repeat (3) put(pack_sample(12'hFFF, 1'b1, 1'b0, 1'b1));
		put(pack_sample(12'hFFF, 1'b1, 1'b0, 1'b0));
		put(pack_sample(12'hFFF, 1'b0, 1'b1, 1'b1));
		repeat (3) put(pack_sample(12'hFFF, 1'b0, 1'b0, 1'b1));
		put(pack_sample(12'd0, 1'b1, 1'b1, 1'b0));
		repeat (3) put(pack_sample(12'd0, 1'b1, 1'b0, 1'b0));

		for (p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				wait_idle();
				case (p)
					1: apply_settings(13'd1, 13'd4096, 13'd4096, 13'd0, 13'd4096, 13'd0, 13'd4096);
					2: apply_settings(13'd6, 13'd1, 13'd1, 13'd4096, 13'd0, 13'd4096, 13'd0);
					// zero span on the x calibration
					3: apply_settings(13'd7, 13'd320, 13'd240, 13'd2000, 13'd2000, 13'd100,
						13'd3900);
					// zero width and an oversized height
					4: apply_settings(13'd2, 13'd0, 13'd8191, 13'd300, 13'd3800, 13'd3800,
						13'd300);
					5: apply_settings(13'($urandom_range(0, 7)), 13'($urandom_range(1, 4096)),
						13'($urandom_range(1, 4096)), 13'($urandom_range(0, 4096)),
						13'($urandom_range(0, 4096)), 13'($urandom_range(0, 4096)),
						13'($urandom_range(0, 4096)));
					default: begin
						write_reg(REG_SPARE, 13'($urandom));
						apply_settings(13'($urandom), 13'($urandom), 13'($urandom),
							13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom));
					end
				endcase
			end
			counted = 0;
			run_random(PHASE_ITEMS);
		end

		wait_idle();
		if (fail_count == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
